FILE: design/ranked_record_bank_selector_top_defines.svh
// Assertion macros for the top file, which checks its own logic.
`ifndef RANKED_RECORD_BANK_SELECTOR_TOP_DEFINES_SVH
`define RANKED_RECORD_BANK_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define RRBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the active-low reset.
`define RRBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rrbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrbs_pkg;

  localparam int unsigned FIT_W  = 17;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned EXCL_W = 5;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned OUT_W  = 4;

  localparam logic [FIT_W-1:0] FIT_ONE   = 17'h10000;
  localparam logic [FIT_W-1:0] FIT_RESET = 17'd1;

  typedef enum logic [1:0] {
    ACT_STORE      = 2'd0,
    ACT_ROULETTE   = 2'd1,
    ACT_TOURNAMENT = 2'd2,
    ACT_RANK       = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SH_INIT,
    ST_SH_RD,
    ST_SH_WR,
    ST_ST_WR,
    ST_SUM,
    ST_MULA,
    ST_TGTA,
    ST_TGTB,
    ST_WALK,
    ST_FALLBK,
    ST_RMUL,
    ST_RFIX,
    ST_RREAD,
    ST_RSLOT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic issue;
    logic scan_en;
    logic sh_init;
    logic sh_read;
    logic sh_write;
    logic st_write;
    logic sum_en;
    logic mul;
    logic mul_sel_b;
    logic mul_rank;
    logic tgt_load;
    logic tgt_min;
    logic walk_en;
    logic fallback;
    logic rfix;
    logic res_read;
    logic res_slot;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    last_live;
    logic    hit;
    logic    sh_done;
    logic    out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/rrbs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrbs_in_if;
  logic                          valid;
  logic                          ready;
  rrbs_pkg::action_e             action;
  logic [rrbs_pkg::FIT_W-1:0]    new_fitness;
  logic [rrbs_pkg::FRAC_W-1:0]   rand_a;
  logic [rrbs_pkg::FRAC_W-1:0]   rand_b;
  logic [rrbs_pkg::EXCL_W-1:0]   exclude_rank;
  logic [rrbs_pkg::CNT_W-1:0]    draw_count;

  modport source (
    output valid, action, new_fitness, rand_a, rand_b, exclude_rank, draw_count,
    input  ready
  );
  modport sink (
    input  valid, action, new_fitness, rand_a, rand_b, exclude_rank, draw_count,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/rrbs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrbs_pkg::OUT_W-1:0]  picked_rank;
  logic [rrbs_pkg::OUT_W-1:0]  picked_slot;

  modport source (
    output valid, picked_rank, picked_slot,
    input  ready
  );
  modport sink (
    input  valid, picked_rank, picked_slot,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/rrbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  rrbs_pkg::action_e    in_action_i,
  output logic                 in_ready_o,
  input  rrbs_pkg::dp_status_t status_i,
  output rrbs_pkg::dp_cmd_t    cmd_o
);
  import rrbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          case (in_action_i)
            ACT_STORE:      state_d = ST_SCAN;
            ACT_ROULETTE:   state_d = ST_SUM;
            ACT_TOURNAMENT: state_d = ST_SUM;
            ACT_RANK:       state_d = ST_RMUL;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.issue   = 1'b1;
        cmd_o.scan_en = 1'b1;
        if (status_i.last_live) begin
          state_d = ST_SH_INIT;
        end
      end
      ST_SH_INIT: begin
        cmd_o.sh_init = 1'b1;
        state_d       = ST_SH_RD;
      end
      ST_SH_RD: begin
        if (status_i.sh_done) begin
          state_d = ST_ST_WR;
        end else begin
          cmd_o.sh_read = 1'b1;
          state_d       = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd_o.sh_write = 1'b1;
        state_d        = ST_SH_RD;
      end
      ST_ST_WR: begin
        cmd_o.st_write = 1'b1;
        state_d        = ST_DONE;
      end
      ST_SUM: begin
        cmd_o.issue  = 1'b1;
        cmd_o.sum_en = 1'b1;
        if (status_i.last_live) begin
          state_d = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_TGTA;
      end
      ST_TGTA: begin
        cmd_o.tgt_load = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        if (status_i.action == ACT_TOURNAMENT) begin
          cmd_o.mul       = 1'b1;
          cmd_o.mul_sel_b = 1'b1;
          state_d         = ST_TGTB;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_TGTB: begin
        cmd_o.tgt_min = 1'b1;
        state_d       = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.issue   = 1'b1;
        cmd_o.walk_en = 1'b1;
        if (status_i.hit) begin
          state_d = ST_DONE;
        end else if (status_i.last_live) begin
          state_d = ST_FALLBK;
        end
      end
      ST_FALLBK: begin
        cmd_o.fallback = 1'b1;
        state_d        = ST_RREAD;
      end
      ST_RMUL: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_rank = 1'b1;
        state_d        = ST_RFIX;
      end
      ST_RFIX: begin
        cmd_o.rfix = 1'b1;
        state_d    = ST_RREAD;
      end
      ST_RREAD: begin
        cmd_o.res_read = 1'b1;
        state_d        = ST_RSLOT;
      end
      ST_RSLOT: begin
        cmd_o.res_slot = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/rrbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbs_dp #(
  parameter int unsigned RECORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrbs_pkg::action_e             action_i,
  input  logic [rrbs_pkg::FIT_W-1:0]    new_fitness_i,
  input  logic [rrbs_pkg::FRAC_W-1:0]   rand_a_i,
  input  logic [rrbs_pkg::FRAC_W-1:0]   rand_b_i,
  input  logic [rrbs_pkg::EXCL_W-1:0]   exclude_rank_i,
  input  logic [rrbs_pkg::CNT_W-1:0]    draw_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rrbs_pkg::OUT_W-1:0]    picked_rank_o,
  output logic [rrbs_pkg::OUT_W-1:0]    picked_slot_o,
  input  rrbs_pkg::dp_cmd_t             cmd_i,
  output rrbs_pkg::dp_status_t          status_o
);
  import rrbs_pkg::*;

  localparam int unsigned SW = $clog2(RECORDS);
  localparam int unsigned CW = $clog2(RECORDS + 1);
  localparam int unsigned TW = FIT_W + SW;
  localparam int unsigned PW = TW + FRAC_W;
  localparam logic [SW-1:0] LAST = SW'(RECORDS - 1);

  typedef struct packed {
    logic [SW-1:0]    slot;
    logic [FIT_W-1:0] fit;
  } row_t;

  row_t              mem [RECORDS];
  logic [RECORDS-1:0] valid_q;

  action_e           action_q;
  logic [FIT_W-1:0]  fit_q;
  logic [FRAC_W-1:0] ra_q;
  logic [FRAC_W-1:0] rb_q;
  logic              ex_ok_q;
  logic [SW-1:0]     ex_rank_q;
  logic [CW-1:0]     n_q;

  logic [CW-1:0]     idx_q;
  logic              rd_live_q;
  logic              rd_vld_q;
  logic [SW-1:0]     rd_addr_q;
  row_t              rd_row_q;

  logic [TW-1:0]     total_q;
  logic [TW-1:0]     acc_q;
  logic [PW-1:0]     prod_q;
  logic [PW-1:0]     target_q;

  logic [CW-1:0]     ins_q;
  logic [SW-1:0]     del_q;
  logic [SW-1:0]     sh_q;
  logic [SW-1:0]     pos_q;
  logic [SW-1:0]     wslot_q;

  logic [SW-1:0]     res_rank_q;
  logic [SW-1:0]     res_slot_q;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_rank_q;
  logic [OUT_W-1:0]  out_slot_q;

  logic [FIT_W-1:0]  fit_sat;
  logic              ex_ok;
  logic [CW-1:0]     n_clamp;
  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  logic              up;
  logic [SW-1:0]     src;
  logic [FIT_W-1:0]  rd_fit;
  logic [SW-1:0]     rd_slot;
  logic              rd_excl;
  logic              counted;
  logic [TW-1:0]     acc_next;
  logic              hit;
  logic              ex_lt_n;
  logic              rk_skip;
  logic [CW-1:0]     multi;
  logic [TW-1:0]     mul_op;
  logic [FRAC_W-1:0] frac;
  logic [SW-1:0]     p_raw;
  logic [SW-1:0]     p_adj;
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  row_t              wr_row;

  always_comb begin
    fit_sat = (new_fitness_i > FIT_ONE) ? FIT_ONE : new_fitness_i;
    ex_ok   = 32'(exclude_rank_i) < RECORDS;
    if (draw_count_i == '0) begin
      n_clamp = CW'(1);
    end else if (32'(draw_count_i) > RECORDS) begin
      n_clamp = CW'(RECORDS);
    end else begin
      n_clamp = CW'(draw_count_i);
    end
  end

  always_comb begin
    up  = ins_q <= CW'(del_q);
    src = up ? (sh_q - SW'(1)) : (sh_q + SW'(1));
    if (cmd_i.issue) begin
      rd_en = 32'(idx_q) < RECORDS;
    end else begin
      rd_en = cmd_i.sh_read | cmd_i.res_read;
    end
    if (cmd_i.sh_read) begin
      rd_addr = src;
    end else if (cmd_i.res_read) begin
      rd_addr = res_rank_q;
    end else begin
      rd_addr = idx_q[SW-1:0];
    end
  end

  always_comb begin
    rd_fit   = rd_vld_q ? rd_row_q.fit : FIT_RESET;
    rd_slot  = rd_vld_q ? rd_row_q.slot : rd_addr_q;
    rd_excl  = ex_ok_q && (rd_addr_q == ex_rank_q);
    counted  = rd_live_q && !rd_excl;
    acc_next = acc_q + TW'(rd_fit);
    hit      = cmd_i.walk_en && counted && ({acc_next, {FRAC_W{1'b0}}} >= target_q);
  end

  always_comb begin
    ex_lt_n = ex_ok_q && (CW'(ex_rank_q) < n_q);
    rk_skip = ex_lt_n && (n_q > CW'(1));
    multi   = rk_skip ? (n_q - CW'(1)) : n_q;
    mul_op  = cmd_i.mul_rank ? TW'(multi) : total_q;
    frac    = cmd_i.mul_sel_b ? rb_q : ra_q;
    p_raw   = prod_q[FRAC_W +: SW];
    p_adj   = (rk_skip && (p_raw >= ex_rank_q)) ? (p_raw + SW'(1)) : p_raw;
  end

  always_comb begin
    wr_en   = cmd_i.sh_write | cmd_i.st_write;
    wr_addr = cmd_i.sh_write ? sh_q : pos_q;
    if (cmd_i.sh_write) begin
      wr_row.slot = rd_slot;
      wr_row.fit  = rd_fit;
    end else begin
      wr_row.slot = wslot_q;
      wr_row.fit  = fit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      rd_live_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      wslot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_live_q <= rd_en;
      rd_vld_q  <= valid_q[rd_addr];
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.issue && (32'(idx_q) < RECORDS)) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.st_write) begin
        wslot_q <= (wslot_q == LAST) ? '0 : (wslot_q + SW'(1));
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
    if (cmd_i.load) begin
      action_q  <= action_i;
      fit_q     <= fit_sat;
      ra_q      <= rand_a_i;
      rb_q      <= rand_b_i;
      ex_ok_q   <= ex_ok;
      ex_rank_q <= SW'(exclude_rank_i);
      n_q       <= n_clamp;
      total_q   <= '0;
      ins_q     <= '0;
      del_q     <= '0;
    end else begin
      if (cmd_i.sum_en && counted) begin
        total_q <= total_q + TW'(rd_fit);
      end
      if (cmd_i.scan_en && rd_live_q) begin
        if (rd_fit > fit_q) begin
          ins_q <= CW'(rd_addr_q) + CW'(1);
        end
        if (rd_slot == wslot_q) begin
          del_q <= rd_addr_q;
        end
      end
    end
    if (cmd_i.idx_clr) begin
      acc_q <= '0;
    end else if (cmd_i.walk_en && counted) begin
      acc_q <= acc_next;
    end
    if (cmd_i.mul) begin
      prod_q <= mul_op * frac;
    end
    if (cmd_i.tgt_load) begin
      target_q <= prod_q;
    end else if (cmd_i.tgt_min) begin
      target_q <= (prod_q < target_q) ? prod_q : target_q;
    end
    if (cmd_i.sh_init) begin
      sh_q  <= del_q;
      pos_q <= up ? SW'(ins_q) : SW'(ins_q - CW'(1));
    end else if (cmd_i.sh_write) begin
      sh_q <= src;
    end
    if (hit) begin
      res_rank_q <= rd_addr_q;
      res_slot_q <= rd_slot;
    end else if (cmd_i.fallback) begin
      res_rank_q <= LAST;
    end else if (cmd_i.rfix) begin
      res_rank_q <= p_adj;
    end else if (cmd_i.res_slot) begin
      res_slot_q <= rd_slot;
    end else if (cmd_i.st_write) begin
      res_rank_q <= pos_q;
      res_slot_q <= wslot_q;
    end
    if (cmd_i.out_load) begin
      out_rank_q <= OUT_W'(res_rank_q);
      out_slot_q <= OUT_W'(res_slot_q);
    end
  end

  assign status_o.action    = action_q;
  assign status_o.last_live = rd_live_q && (rd_addr_q == LAST);
  assign status_o.hit       = hit;
  assign status_o.sh_done   = sh_q == pos_q;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign picked_rank_o = out_rank_q;
  assign picked_slot_o = out_slot_q;

endmodule

`default_nettype wire

FILE: design/ranked_record_bank_selector_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ranked_record_bank_selector_top_defines.svh"

// Ranked fitness bank with roulette, tournament and rank selection. The block
// holds RECORDS records in one rank-ordered memory (slot and fitness per rank)
// with a single read and a single write port, and takes one transaction at a
// time. All walks stream that read port, one rank a cycle. A roulette or
// tournament pick makes one total pass and one running-sum walk that stops
// at the first hit. A store scans the bank, then moves each record between
// its old and new place by one rank. A finished result waits in an output
// register, and the next transaction is taken while it waits.
module ranked_record_bank_selector_top #(
  parameter int unsigned RECORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrbs_in_if.sink     in_i,
  rrbs_out_if.source  out_o
);
  import rrbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  rrbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rrbs_dp #(
    .RECORDS (RECORDS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (in_i.action),
    .new_fitness_i  (in_i.new_fitness),
    .rand_a_i       (in_i.rand_a),
    .rand_b_i       (in_i.rand_b),
    .exclude_rank_i (in_i.exclude_rank),
    .draw_count_i   (in_i.draw_count),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .picked_rank_o  (out_o.picked_rank),
    .picked_slot_o  (out_o.picked_slot),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  assign in_i.ready = in_ready;

  `RRBS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "ready stayed high after a transaction was accepted")
  `RRBS_ASSERT_IMPL(a_result_after_busy, clk_i, rst_ni, $rose(out_o.valid), $past(!in_i.ready), "result appeared without a transaction in progress")
  `RRBS_ASSERT_IMPL(a_rank_in_range, clk_i, rst_ni, out_o.valid, (RECORDS > 16) || (32'(out_o.picked_rank) < RECORDS), "picked rank beyond the bank")

endmodule

`default_nettype wire
